/* rtl/snmc_pkg.sv */
// ----------------------------------------------------------------------------
// snmc_pkg
// shared types and constants of the sensor node mode controller
// ----------------------------------------------------------------------------
package snmc_pkg;

   localparam int DIST_W      = 16;
   localparam int CMD_W       = 5;
   localparam int ERR_CNT_W   = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [DIST_W-1:0] MIN_RANGE_RESET = 16'd30;
   localparam logic [DIST_W-1:0] MAX_RANGE_RESET = 16'd2000;

   // register indexes of the csr port
   localparam logic REG_MIN_RANGE = 1'b0;
   localparam logic REG_MAX_RANGE = 1'b1;

   // request kinds on the wire
   localparam logic REQ_COMMAND = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   // command codes on the wire
   localparam logic [CMD_W-1:0] CMD_INIT    = 5'd0;
   localparam logic [CMD_W-1:0] CMD_CHANGE  = 5'd1;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 5'd2;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 5'd3;

   typedef enum logic [1:0] {
      MODE_INIT    = 2'd0,
      MODE_CHANGE  = 2'd1,
      MODE_ENABLE  = 2'd2,
      MODE_DISABLE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RES_NONE   = 2'd0,
      RES_OK     = 2'd1,
      RES_REJECT = 2'd2
   } result_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_INIT    = 3'd1,
      OP_CHANGE  = 3'd2,
      OP_ENABLE  = 3'd3,
      OP_DISABLE = 3'd4,
      OP_IGNORE  = 3'd5
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [DIST_W-1:0] sample_mm;
      logic              sample_timeout;
   } entry_type;

   typedef struct packed {
      mode_type             mode;
      result_type           cmd_result;
      logic                 distance_valid;
      logic [DIST_W-1:0]    distance_mm;
      logic [ERR_CNT_W-1:0] error_count;
      logic                 initialized;
      logic                 feedback_due;
      logic                 start_sensor_init;
      logic                 start_ranging;
      logic                 stop_ranging;
   } rsp_type;

endpackage

/* rtl/snmc_if.sv */
// ----------------------------------------------------------------------------
// snmc_if
// request and response channel interfaces of the mode controller
// ----------------------------------------------------------------------------
interface snmc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [snmc_pkg::CMD_W-1:0]    cmd_code;
   logic [snmc_pkg::DIST_W-1:0]   sample_mm;
   logic                          sample_timeout;

   modport source (output valid, req_type, cmd_code, sample_mm, sample_timeout,
                   input ready);
   modport sink   (input valid, req_type, cmd_code, sample_mm, sample_timeout,
                   output ready);
endinterface

interface snmc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      mode;
   logic [1:0]                      cmd_result;
   logic                            distance_valid;
   logic [snmc_pkg::DIST_W-1:0]     distance_mm;
   logic [snmc_pkg::ERR_CNT_W-1:0]  error_count;
   logic                            initialized;
   logic                            feedback_due;
   logic                            start_sensor_init;
   logic                            start_ranging;
   logic                            stop_ranging;

   modport source (output valid, mode, cmd_result, distance_valid, distance_mm,
                   error_count, initialized, feedback_due, start_sensor_init,
                   start_ranging, stop_ranging,
                   input ready);
   modport sink   (input valid, mode, cmd_result, distance_valid, distance_mm,
                   error_count, initialized, feedback_due, start_sensor_init,
                   start_ranging, stop_ranging,
                   output ready);
endinterface

/* rtl/snmc_front.sv */
// ----------------------------------------------------------------------------
// snmc_front
// accepts requests and classifies them into queue entries
// ----------------------------------------------------------------------------
module snmc_front (
   snmc_req_if.sink              req_ch,
   output logic                  push_valid,
   input  logic                  push_ready,
   output snmc_pkg::entry_type   push_entry
);
   import snmc_pkg::*;

   op_type op;

   always_comb begin
      if (req_ch.req_type == REQ_TICK) begin
         op = OP_TICK;
      end else begin
         case (req_ch.cmd_code)
            CMD_INIT:    op = OP_INIT;
            CMD_CHANGE:  op = OP_CHANGE;
            CMD_ENABLE:  op = OP_ENABLE;
            CMD_DISABLE: op = OP_DISABLE;
            default:     op = OP_IGNORE;
         endcase
      end
   end

   assign push_valid                = req_ch.valid;
   assign req_ch.ready              = push_ready;
   assign push_entry.op             = op;
   assign push_entry.sample_mm      = req_ch.sample_mm;
   assign push_entry.sample_timeout = req_ch.sample_timeout;

endmodule

/* rtl/snmc_queue.sv */
// ----------------------------------------------------------------------------
// snmc_queue
// small register queue between classifier and executor
// ----------------------------------------------------------------------------
module snmc_queue #(
   parameter int DEPTH = snmc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  snmc_pkg::entry_type   push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output snmc_pkg::entry_type   pop_entry
);
   import snmc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/snmc_back.sv */
// ----------------------------------------------------------------------------
// snmc_back
// executes commands and ticks, holds mode state and the response register
// ----------------------------------------------------------------------------
module snmc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [snmc_pkg::DIST_W-1:0]   min_range_mm,
   input  logic [snmc_pkg::DIST_W-1:0]   max_range_mm,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  snmc_pkg::entry_type           pop_entry,
   snmc_rsp_if.source                    rsp_ch
);
   import snmc_pkg::*;

   mode_type             mode_ff, mode_in;
   logic                 init_seen_ff, init_seen_in;
   logic                 init_done_ff, init_done_in;
   logic                 init_pend_ff, init_pend_in;
   logic                 en_pend_ff, en_pend_in;
   logic                 dis_pend_ff, dis_pend_in;
   logic [ERR_CNT_W-1:0] err_cnt_ff, err_cnt_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 dist_valid_ff, dist_valid_in;
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           result;
   logic                 p_init, p_start, p_stop;
   logic                 in_window;
   logic                 pop_fire;

   assign pop_ready = !out_valid_ff || rsp_ch.ready;
   assign pop_fire  = pop_valid && pop_ready;
   assign in_window = !pop_entry.sample_timeout
                      && (pop_entry.sample_mm <= max_range_mm)
                      && (pop_entry.sample_mm >= min_range_mm);

   always_comb begin
      mode_in       = mode_ff;
      init_seen_in  = init_seen_ff;
      init_done_in  = init_done_ff;
      init_pend_in  = init_pend_ff;
      en_pend_in    = en_pend_ff;
      dis_pend_in   = dis_pend_ff;
      err_cnt_in    = err_cnt_ff;
      dist_in       = dist_ff;
      dist_valid_in = dist_valid_ff;
      result        = RES_NONE;
      p_init        = 1'b0;
      p_start       = 1'b0;
      p_stop        = 1'b0;
      if (pop_fire) begin
         case (pop_entry.op)
            OP_INIT: begin
               if (init_done_ff) begin
                  result = RES_REJECT;
               end else begin
                  init_seen_in = 1'b1;
                  init_pend_in = 1'b1;
                  result       = RES_OK;
               end
            end
            OP_CHANGE: begin
               if (!init_seen_ff) begin
                  result = RES_REJECT;
               end else if (mode_ff == MODE_ENABLE) begin
                  result     = RES_REJECT;
                  err_cnt_in = err_cnt_ff + 1'b1;
               end else begin
                  mode_in      = MODE_CHANGE;
                  init_done_in = 1'b1;
                  result       = RES_OK;
               end
            end
            OP_ENABLE: begin
               if (mode_ff != MODE_CHANGE && mode_ff != MODE_DISABLE) begin
                  result     = RES_REJECT;
                  err_cnt_in = err_cnt_ff + 1'b1;
               end else begin
                  en_pend_in = 1'b1;
                  result     = RES_OK;
               end
            end
            OP_DISABLE: begin
               if (mode_ff != MODE_ENABLE) begin
                  result     = RES_REJECT;
                  err_cnt_in = err_cnt_ff + 1'b1;
               end else begin
                  dis_pend_in = 1'b1;
                  result      = RES_OK;
               end
            end
            OP_TICK: begin
               // pendings apply in order init, enable, disable
               p_init       = init_pend_ff;
               init_pend_in = 1'b0;
               en_pend_in   = 1'b0;
               dis_pend_in  = 1'b0;
               if (en_pend_ff) begin
                  mode_in = MODE_ENABLE;
                  p_start = 1'b1;
               end
               if (dis_pend_ff) begin
                  mode_in = MODE_DISABLE;
                  p_stop  = 1'b1;
               end
               if (mode_in == MODE_ENABLE) begin
                  dist_valid_in = in_window;
                  dist_in       = in_window ? pop_entry.sample_mm : '0;
               end else if (mode_in != MODE_INIT) begin
                  dist_valid_in = 1'b0;
                  dist_in       = '0;
               end
            end
            default: begin
               result = RES_NONE;
            end
         endcase
      end

      out_in.mode              = mode_in;
      out_in.cmd_result        = result;
      out_in.distance_valid    = dist_valid_in;
      out_in.distance_mm       = dist_valid_in ? dist_in : '0;
      out_in.error_count       = err_cnt_in;
      out_in.initialized       = init_done_in;
      out_in.feedback_due      = (mode_in != MODE_INIT);
      out_in.start_sensor_init = p_init;
      out_in.start_ranging     = p_start;
      out_in.stop_ranging      = p_stop;

      if (pop_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_INIT;
         init_seen_ff  <= 1'b0;
         init_done_ff  <= 1'b0;
         init_pend_ff  <= 1'b0;
         en_pend_ff    <= 1'b0;
         dis_pend_ff   <= 1'b0;
         err_cnt_ff    <= '0;
         dist_ff       <= '0;
         dist_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         init_seen_ff  <= init_seen_in;
         init_done_ff  <= init_done_in;
         init_pend_ff  <= init_pend_in;
         en_pend_ff    <= en_pend_in;
         dis_pend_ff   <= dis_pend_in;
         err_cnt_ff    <= err_cnt_in;
         dist_ff       <= dist_in;
         dist_valid_ff <= dist_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.mode              = out_ff.mode;
   assign rsp_ch.cmd_result        = out_ff.cmd_result;
   assign rsp_ch.distance_valid    = out_ff.distance_valid;
   assign rsp_ch.distance_mm       = out_ff.distance_mm;
   assign rsp_ch.error_count       = out_ff.error_count;
   assign rsp_ch.initialized       = out_ff.initialized;
   assign rsp_ch.feedback_due      = out_ff.feedback_due;
   assign rsp_ch.start_sensor_init = out_ff.start_sensor_init;
   assign rsp_ch.start_ranging     = out_ff.start_ranging;
   assign rsp_ch.stop_ranging      = out_ff.stop_ranging;

`ifndef SYNTHESIS
   // enable and disable can never be pending together
   a_pend_excl: assert property (@(posedge clock) disable iff (reset)
      !(en_pend_ff && dis_pend_ff))
      else $error("enable and disable pending together");

   // at most one ranging pulse per response
   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({out_ff.start_ranging, out_ff.stop_ranging}))
      else $error("start and stop ranging in one response");

   // a stop pulse always reports disable mode
   a_stop_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.stop_ranging) |-> (out_ff.mode == MODE_DISABLE))
      else $error("stop pulse outside disable mode");

   // the error count moves by at most one per cycle
   a_err_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (err_cnt_ff == $past(err_cnt_ff))
               || (err_cnt_ff == $past(err_cnt_ff) + 1'b1))
      else $error("error count jumped");

   // a held valid distance exists only while enabled
   a_valid_mode: assert property (@(posedge clock) disable iff (reset)
      dist_valid_ff |-> (mode_ff == MODE_ENABLE))
      else $error("valid distance outside enable mode");
`endif

endmodule

/* rtl/sensor_node_mode_controller_top.sv */
// ----------------------------------------------------------------------------
// sensor_node_mode_controller_top
// mode controller for a networked range sensor node
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_ch    in         valid / ready        req_type, cmd_code, sample_mm,
//                                            sample_timeout
//  rsp_ch    out        valid / ready        mode, cmd_result, distance,
//                                            error_count, flags, pulses
//  csr       in         psel/penable/pready  min_range_mm @0, max_range_mm @4
//
//  one request per cycle sustained while rsp_ch.ready stays high, one response per request
//  between request transfer and response transfer a request is classified
//  into the queue, then executed into the response register
//  the response register frees as its transfer completes, so a stalled
//  response side fills the queue before req_ch.ready drops
//  synchronous active-high reset clears mode, flags, counts and queue
// ----------------------------------------------------------------------------
module sensor_node_mode_controller_top #(
   parameter int QUEUE_DEPTH = snmc_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   snmc_req_if.sink                          req_ch,
   snmc_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [snmc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [snmc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [snmc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import snmc_pkg::*;

   // range window registers
   logic [DIST_W-1:0] min_range_ff, min_range_in;
   logic [DIST_W-1:0] max_range_ff, max_range_in;
   logic              csr_write;
   logic              csr_index;

   // front to queue
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // queue to back
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // csr port: zero wait states, word-aligned byte addresses (bit 2 selects)
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      min_range_in = min_range_ff;
      max_range_in = max_range_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MIN_RANGE: min_range_in = pwdata[DIST_W-1:0];
            REG_MAX_RANGE: max_range_in = pwdata[DIST_W-1:0];
            default:       min_range_in = min_range_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MIN_RANGE: prdata = {{(CSR_DATA_W-DIST_W){1'b0}}, min_range_ff};
         REG_MAX_RANGE: prdata = {{(CSR_DATA_W-DIST_W){1'b0}}, max_range_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= MIN_RANGE_RESET;
         max_range_ff <= MAX_RANGE_RESET;
      end else begin
         min_range_ff <= min_range_in;
         max_range_ff <= max_range_in;
      end
   end

   // front: take the request transfer and classify it
   snmc_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // queue decouples request side from response side
   snmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // back: mode state, pulses, distance check, response register
   snmc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_range_mm (min_range_ff),
      .max_range_mm (max_range_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_ch       (rsp_ch)
   );

endmodule

/* tb/tb_sensor_node_mode_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_node_mode_controller_top
// self-checking bench for the sensor node mode controller: commands and ticks
// go in with random gaps, status frames come out against random stalls, and
// every frame is compared field by field with a cycle-free status predictor
// ----------------------------------------------------------------------------
module tb_sensor_node_mode_controller_top;
   import snmc_pkg::*;

   // command codes that the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED_LOW = 5'd4;
   localparam logic [CMD_W-1:0] CMD_UNUSED_TOP = 5'd31;

   // predicted node state and the queue of status frames still owed
   class node_status_board;
      logic [DIST_W-1:0]    min_range;
      logic [DIST_W-1:0]    max_range;
      mode_type             mode;
      bit                   init_seen;
      bit                   init_done;
      bit                   init_pending;
      bit                   enable_pending;
      bit                   disable_pending;
      logic [ERR_CNT_W-1:0] reject_count;
      logic [DIST_W-1:0]    held_distance;
      bit                   held_valid;
      rsp_type              status_due[$];
      int                   mismatches;

      function new();
         min_range       = MIN_RANGE_RESET;
         max_range       = MAX_RANGE_RESET;
         mode            = MODE_INIT;
         init_seen       = 1'b0;
         init_done       = 1'b0;
         init_pending    = 1'b0;
         enable_pending  = 1'b0;
         disable_pending = 1'b0;
         reject_count    = '0;
         held_distance   = '0;
         held_valid      = 1'b0;
         mismatches      = 0;
      endfunction

      function void set_range(logic index, logic [DIST_W-1:0] value);
         if (index == REG_MIN_RANGE) min_range = value;
         else                        max_range = value;
      endfunction

      // advance the state by one accepted request and queue its status
      function void log_request(logic kind, logic [CMD_W-1:0] code,
                                logic [DIST_W-1:0] range_mm, logic timeout);
         rsp_type    want;
         result_type outcome;
         want    = '0;
         outcome = RES_NONE;
         if (kind == REQ_COMMAND) begin
            case (code)
               CMD_INIT: begin
                  // init is refused once change control has been taken
                  if (init_done) begin
                     outcome = RES_REJECT;
                  end else begin
                     init_seen    = 1'b1;
                     init_pending = 1'b1;
                     outcome      = RES_OK;
                  end
               end
               CMD_CHANGE: begin
                  if (!init_seen) begin
                     outcome = RES_REJECT;
                  end else if (mode == MODE_ENABLE) begin
                     reject_count = reject_count + 1'b1;
                     outcome      = RES_REJECT;
                  end else begin
                     mode      = MODE_CHANGE;
                     init_done = 1'b1;
                     outcome   = RES_OK;
                  end
               end
               CMD_ENABLE: begin
                  if (mode != MODE_CHANGE && mode != MODE_DISABLE) begin
                     reject_count = reject_count + 1'b1;
                     outcome      = RES_REJECT;
                  end else begin
                     enable_pending = 1'b1;
                     outcome        = RES_OK;
                  end
               end
               CMD_DISABLE: begin
                  if (mode != MODE_ENABLE) begin
                     reject_count = reject_count + 1'b1;
                     outcome      = RES_REJECT;
                  end else begin
                     disable_pending = 1'b1;
                     outcome         = RES_OK;
                  end
               end
               default: outcome = RES_NONE;
            endcase
         end else begin
            // pendings fire in order init, enable, disable
            if (init_pending) begin
               init_pending           = 1'b0;
               want.start_sensor_init = 1'b1;
            end
            if (enable_pending) begin
               enable_pending     = 1'b0;
               mode               = MODE_ENABLE;
               want.start_ranging = 1'b1;
            end
            if (disable_pending) begin
               disable_pending   = 1'b0;
               mode              = MODE_DISABLE;
               want.stop_ranging = 1'b1;
            end
            if (mode == MODE_ENABLE) begin
               if (!timeout && range_mm >= min_range && range_mm <= max_range) begin
                  held_valid    = 1'b1;
                  held_distance = range_mm;
               end else begin
                  held_valid    = 1'b0;
                  held_distance = '0;
               end
            end else if (mode != MODE_INIT) begin
               held_valid    = 1'b0;
               held_distance = '0;
            end
         end
         want.mode           = mode;
         want.cmd_result     = outcome;
         want.distance_valid = held_valid;
         want.distance_mm    = held_valid ? held_distance : '0;
         want.error_count    = reject_count;
         want.initialized    = init_done;
         want.feedback_due   = (mode != MODE_INIT);
         status_due.push_back(want);
      endfunction

      task report(string line);
         mismatches++;
         $display("%0t ns: %s", $time, line);
      endtask

      task compare(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s mismatch: got %0h, expected %0h", field, got, want));
      endtask

      task check_status(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            report("status transfer with no status expected");
         end else begin
            want = status_due.pop_front();
            compare("mode", got.mode, want.mode);
            compare("cmd_result", got.cmd_result, want.cmd_result);
            compare("distance_valid", got.distance_valid, want.distance_valid);
            compare("distance_mm", got.distance_mm, want.distance_mm);
            compare("error_count", got.error_count, want.error_count);
            compare("initialized", got.initialized, want.initialized);
            compare("feedback_due", got.feedback_due, want.feedback_due);
            compare("start_sensor_init", got.start_sensor_init, want.start_sensor_init);
            compare("start_ranging", got.start_ranging, want.start_ranging);
            compare("stop_ranging", got.stop_ranging, want.stop_ranging);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   snmc_req_if req_ch();
   snmc_rsp_if rsp_ch();

   node_status_board board;
   rsp_type          seen_status;

   // remaining no-wait draws of a calm stretch, one per side
   int send_calm = 0;
   int sink_calm = 0;

   sensor_node_mode_controller_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #6 clock = ~clock;

   // random wait before the next transfer, with calm stretches of no wait
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 16);
   endfunction

   // one request transfer; valid stays high when the next one follows at once
   task automatic send_request(input logic kind, input logic [CMD_W-1:0] code,
                               input logic [DIST_W-1:0] range_mm, input logic timeout);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.req_type       <= kind;
      req_ch.cmd_code       <= code;
      req_ch.sample_mm      <= range_mm;
      req_ch.sample_timeout <= timeout;
      do @(posedge clock); while (!req_ch.ready);
      board.log_request(kind, code, range_mm, timeout);
   endtask

   // stop sending and let every owed status frame come out
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (board.status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup and access cycle; upper data bits are junk the register drops
   task automatic csr_write(input logic index, input logic [DIST_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({index, 2'b00});
      pwdata  <= {16'($urandom()), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      board.set_range(index, value);
   endtask

   // new range window while idle, then a run of random requests;
   // legal_pct sets how often a command fits the predicted mode
   task automatic run_phase(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi,
                            input int count, input int legal_pct);
      int                pick;
      logic              kind;
      logic [CMD_W-1:0]  code;
      logic [DIST_W-1:0] range_mm;
      logic              timeout;
      logic [CMD_W-1:0]  allowed[$];
      drain();
      csr_write(REG_MIN_RANGE, lo);
      csr_write(REG_MAX_RANGE, hi);
      repeat (count) begin
         pick     = $urandom_range(0, 99);
         kind     = REQ_COMMAND;
         code     = CMD_W'($urandom());
         range_mm = DIST_W'($urandom());
         timeout  = ($urandom_range(0, 7) == 0);
         if (pick < 45) begin
            kind = REQ_TICK;
            // half the ticks sit within two of a window edge
            case ($urandom_range(0, 3))
               0: range_mm = board.min_range + DIST_W'($urandom_range(0, 4)) - DIST_W'(2);
               1: range_mm = board.max_range + DIST_W'($urandom_range(0, 4)) - DIST_W'(2);
               default: ;
            endcase
         end else if (pick < 50) begin
            code = CMD_W'($urandom_range(CMD_UNUSED_LOW, CMD_UNUSED_TOP));
         end else if ($urandom_range(0, 99) >= legal_pct) begin
            code = CMD_W'($urandom_range(CMD_INIT, CMD_DISABLE));
         end else begin
            allowed.delete();
            case (board.mode)
               MODE_INIT: begin
                  allowed.push_back(CMD_INIT);
                  if (board.init_seen) allowed.push_back(CMD_CHANGE);
               end
               MODE_CHANGE: begin
                  allowed.push_back(CMD_CHANGE);
                  allowed.push_back(CMD_ENABLE);
               end
               MODE_ENABLE: allowed.push_back(CMD_DISABLE);
               default: begin
                  allowed.push_back(CMD_ENABLE);
                  allowed.push_back(CMD_CHANGE);
               end
            endcase
            code = allowed[$urandom_range(0, allowed.size() - 1)];
         end
         send_request(kind, code, range_mm, timeout);
      end
   endtask

   // status sink: random stall before each transfer
   initial begin : status_sink
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(sink_calm);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // status monitor: every transfer is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_status.mode              = mode_type'(rsp_ch.mode);
         seen_status.cmd_result        = result_type'(rsp_ch.cmd_result);
         seen_status.distance_valid    = rsp_ch.distance_valid;
         seen_status.distance_mm       = rsp_ch.distance_mm;
         seen_status.error_count       = rsp_ch.error_count;
         seen_status.initialized       = rsp_ch.initialized;
         seen_status.feedback_due      = rsp_ch.feedback_due;
         seen_status.start_sensor_init = rsp_ch.start_sensor_init;
         seen_status.start_ranging     = rsp_ch.start_ranging;
         seen_status.stop_ranging      = rsp_ch.stop_ranging;
         board.check_status(seen_status);
      end
   end

   initial begin : stimulus
      logic [DIST_W-1:0] lo;
      logic [DIST_W-1:0] hi;
      board                 = new();
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.req_type       = REQ_COMMAND;
      req_ch.cmd_code       = CMD_INIT;
      req_ch.sample_mm      = '0;
      req_ch.sample_timeout = 1'b0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk through the mode graph with the reset window 30..2000
      send_request(REQ_TICK,    CMD_DISABLE, 16'hFFFF, 1'b1);  // tick in init keeps distance
      send_request(REQ_COMMAND, CMD_CHANGE,  16'h0000, 1'b0);  // change before init, no count
      send_request(REQ_COMMAND, CMD_ENABLE,  16'h0000, 1'b0);  // enable from init counts
      send_request(REQ_COMMAND, CMD_DISABLE, 16'hFFFF, 1'b1);  // disable from init counts
      send_request(REQ_COMMAND, CMD_UNUSED_TOP, 16'h0000, 1'b0);  // ignored code
      send_request(REQ_COMMAND, CMD_UNUSED_LOW, 16'h0000, 1'b0);
      send_request(REQ_COMMAND, CMD_INIT,    16'h0000, 1'b0);
      send_request(REQ_TICK,    CMD_INIT,    16'd500,  1'b0);  // sensor init pulse
      send_request(REQ_COMMAND, CMD_INIT,    16'h0000, 1'b0);  // init again before change
      send_request(REQ_COMMAND, CMD_CHANGE,  16'h0000, 1'b0);
      send_request(REQ_COMMAND, CMD_INIT,    16'h0000, 1'b0);  // init once initialized
      send_request(REQ_COMMAND, CMD_ENABLE,  16'h0000, 1'b0);
      send_request(REQ_COMMAND, CMD_DISABLE, 16'h0000, 1'b0);  // disable while only armed
      send_request(REQ_TICK,    CMD_UNUSED_TOP, 16'd29, 1'b0);  // init and start together
      send_request(REQ_TICK,    CMD_INIT,    16'd30,   1'b0);  // window edges
      send_request(REQ_TICK,    CMD_INIT,    16'd2000, 1'b0);
      send_request(REQ_TICK,    CMD_INIT,    16'd2001, 1'b0);
      send_request(REQ_TICK,    CMD_INIT,    16'd1000, 1'b1);  // timed out read
      send_request(REQ_COMMAND, CMD_CHANGE,  16'h0000, 1'b0);  // change from enable
      send_request(REQ_COMMAND, CMD_ENABLE,  16'h0000, 1'b0);  // enable while enabled
      send_request(REQ_COMMAND, CMD_DISABLE, 16'h0000, 1'b0);
      send_request(REQ_TICK,    CMD_INIT,    16'd100,  1'b0);  // stop pulse, distance dropped
      send_request(REQ_COMMAND, CMD_ENABLE,  16'h0000, 1'b0);
      send_request(REQ_TICK,    CMD_INIT,    16'h0000, 1'b0);

      // random phases, each behind its own window; the sender waits out
      // every owed frame before each window change
      run_phase(16'h0000, 16'hFFFF, 180, 75);
      run_phase(16'hFFFF, 16'h0000, 150, 75);  // minimum above maximum
      run_phase(16'h0000, 16'h0000, 120, 75);
      run_phase(16'hFFFF, 16'hFFFF, 120, 75);
      lo = DIST_W'($urandom_range(0, 32767));
      hi = DIST_W'($urandom_range(lo, 65535));
      run_phase(lo, hi, 200, 20);  // mostly commands drawn without regard to the predicted mode
      run_phase(MIN_RANGE_RESET, MAX_RANGE_RESET, 280, 75);

      drain();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("[sensor_node_mode_controller_top] OK");
      else
         $display("[sensor_node_mode_controller_top] ERROR");
      $finish;
   end

   // watchdog, far above the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("[sensor_node_mode_controller_top] ERROR");
      $finish;
   end

endmodule
